// File: rtl/assert_macros.svh
// assertion macros shared by the eikonal update rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`endif

// File: rtl/edu_pkg.sv
// shared widths, register codes and stage payload types of the eikonal update
// no dependencies
`default_nettype none

package edu_pkg;

    localparam int MAG_W       = 32;
    localparam int REG_W       = 31;
    localparam int CFG_IDX_W   = 1;
    localparam int SQ_W        = 2 * REG_W;
    localparam int RAD_W       = 64;
    localparam int ROOT_STAGES = RAD_W / 2;
    localparam int REM_W       = MAG_W + 3;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_SPACING = 1'd0;
    localparam t_cfg_idx CFG_NARROW_BAND  = 1'd1;

    localparam logic [REG_W-1:0] GRID_SPACING_RST = 31'd65536;
    localparam logic [REG_W-1:0] NARROW_BAND_RST  = 31'd327680;

    typedef struct packed {
        logic [REG_W-1:0] grid_spacing;
        logic [REG_W-1:0] narrow_band;
    } t_cfg;

    // values that ride alongside the square root
    typedef struct packed {
        logic [MAG_W:0] near_sum;   // min(a, b) + dx
        logic [MAG_W:0] pair_sum;   // a + b
        logic           upwind;     // |a - b| >= dx
        logic           neg;
    } t_side;

    // one stage of the digit-by-digit square root
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
        t_side            side;
    } t_root;

endpackage

`default_nettype wire

// File: rtl/edu_req_if.sv
// request channel interface: neighbor magnitudes, present bits and cell sign
// no dependencies
`default_nettype none

interface edu_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_mag;
    logic [31:0] right_mag;
    logic [31:0] below_mag;
    logic [31:0] above_mag;
    logic        has_left;
    logic        has_right;
    logic        has_below;
    logic        has_above;
    logic        center_negative;

    modport source (
        output valid, left_mag, right_mag, below_mag, above_mag,
               has_left, has_right, has_below, has_above, center_negative,
        input  ready
    );
    modport sink (
        input  valid, left_mag, right_mag, below_mag, above_mag,
               has_left, has_right, has_below, has_above, center_negative,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/edu_res_if.sv
// result channel interface: raw distance, signed clamped distance, clamp flag
// no dependencies
`default_nettype none

interface edu_res_if;
    logic               valid;
    logic               ready;
    logic        [31:0] raw_distance;
    logic signed [31:0] signed_distance;
    logic               band_clamped;

    modport source (
        output valid, raw_distance, signed_distance, band_clamped,
        input  ready
    );
    modport sink (
        input  valid, raw_distance, signed_distance, band_clamped,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/edu_cfg.sv
// configuration registers: grid spacing and narrow band
// depends on edu_pkg
`default_nettype none

module edu_cfg (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire edu_pkg::t_cfg_idx        i_cfg_idx,
    input  wire logic [edu_pkg::REG_W-1:0] i_cfg_data,
    output edu_pkg::t_cfg                 o_cfg
);

    edu_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_spacing <= edu_pkg::GRID_SPACING_RST;
            r_cfg.narrow_band  <= edu_pkg::NARROW_BAND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                edu_pkg::CFG_GRID_SPACING: r_cfg.grid_spacing <= i_cfg_data;
                edu_pkg::CFG_NARROW_BAND:  r_cfg.narrow_band  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/edu_front.sv
// front pipeline: axis minima, upwind test, squares and discriminant (4 stages)
// depends on edu_pkg and edu_req_if
`default_nettype none

module edu_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    edu_req_if.sink                        i_req,
    input  wire logic [edu_pkg::REG_W-1:0] i_grid_spacing,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output edu_pkg::t_root                 o_data
);

    localparam int MW = edu_pkg::MAG_W;
    localparam int RW = edu_pkg::REG_W;
    localparam int SW = edu_pkg::SQ_W;

    function automatic logic [MW-1:0] take_mag(input logic [MW-1:0] mag, input logic has);
        return has ? mag : '1;
    endfunction

    function automatic logic [MW-1:0] min_mag(input logic [MW-1:0] x, input logic [MW-1:0] y);
        return (x < y) ? x : y;
    endfunction

    // stage registers
    logic          r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [MW-1:0] r_s1_a, r_s1_b;
    logic          r_s1_neg;
    logic [RW-1:0] r_s2_diff;
    edu_pkg::t_side r_s2_side, r_s3_side;
    logic [SW-1:0] r_s3_sq_dx, r_s3_sq_diff;
    edu_pkg::t_root r_s4_data;

    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    // stall chain: a stage takes new data when empty or draining
    assign s4_rdy = !r_s4_vld || i_ready;
    assign s3_rdy = !r_s3_vld || s4_rdy;
    assign s2_rdy = !r_s2_vld || s3_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign i_req.ready = s1_rdy;

    // stage 1: per-axis minimum with missing neighbors far away
    logic [MW-1:0] n_s1_a, n_s1_b;
    always_comb begin
        n_s1_a = min_mag(take_mag(i_req.left_mag, i_req.has_left),
                         take_mag(i_req.right_mag, i_req.has_right));
        n_s1_b = min_mag(take_mag(i_req.below_mag, i_req.has_below),
                         take_mag(i_req.above_mag, i_req.has_above));
    end

    // stage 2: ordering, difference, upwind test and sums
    logic [MW-1:0]  s2_lo, s2_hi, s2_diff;
    edu_pkg::t_side n_s2_side;
    always_comb begin
        s2_lo   = (r_s1_a < r_s1_b) ? r_s1_a : r_s1_b;
        s2_hi   = (r_s1_a < r_s1_b) ? r_s1_b : r_s1_a;
        s2_diff = s2_hi - s2_lo;
        n_s2_side.upwind   = s2_diff >= {1'b0, i_grid_spacing};
        n_s2_side.near_sum = {1'b0, s2_lo} + {2'b0, i_grid_spacing};
        n_s2_side.pair_sum = {1'b0, r_s1_a} + {1'b0, r_s1_b};
        n_s2_side.neg      = r_s1_neg;
    end

    // stage 3: squares of spacing and difference
    logic [SW-1:0] s3_dx_ext, s3_diff_ext;
    assign s3_dx_ext   = SW'(i_grid_spacing);
    assign s3_diff_ext = SW'(r_s2_diff);

    // stage 4: discriminant 2*dx*dx - diff*diff, seeds the root
    edu_pkg::t_root n_s4_data;
    always_comb begin
        n_s4_data.rad  = {1'b0, r_s3_sq_dx, 1'b0} - {2'b0, r_s3_sq_diff};
        n_s4_data.rem  = '0;
        n_s4_data.root = '0;
        n_s4_data.side = r_s3_side;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_vld <= i_req.valid;
            if (s2_rdy) r_s2_vld <= r_s1_vld;
            if (s3_rdy) r_s3_vld <= r_s2_vld;
            if (s4_rdy) r_s4_vld <= r_s3_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_a   <= n_s1_a;
            r_s1_b   <= n_s1_b;
            r_s1_neg <= i_req.center_negative;
        end
        if (s2_rdy) begin
            r_s2_diff <= s2_diff[RW-1:0];
            r_s2_side <= n_s2_side;
        end
        if (s3_rdy) begin
            r_s3_sq_dx   <= s3_dx_ext * s3_dx_ext;
            r_s3_sq_diff <= s3_diff_ext * s3_diff_ext;
            r_s3_side    <= r_s2_side;
        end
        if (s4_rdy) begin
            r_s4_data <= n_s4_data;
        end
    end

    assign o_valid = r_s4_vld;
    assign o_data  = r_s4_data;

endmodule

`default_nettype wire

// File: rtl/edu_root_step.sv
// one registered step of the digit-by-digit integer square root (one root bit)
// depends on edu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module edu_root_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire edu_pkg::t_root i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output edu_pkg::t_root      o_data
);

    localparam int MW = edu_pkg::MAG_W;
    localparam int XW = edu_pkg::REM_W;
    localparam int DW = edu_pkg::RAD_W;

    logic           r_vld;
    edu_pkg::t_root r_data;
    edu_pkg::t_root n_data;
    logic [XW-1:0]  rem_sh, trial;

    assign o_ready = !r_vld || i_ready;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {i_data.rem[XW-3:0], i_data.rad[DW-1 -: 2]};
        trial  = {1'b0, i_data.root, 2'b01};
        n_data = i_data;
        n_data.rad = {i_data.rad[DW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[MW-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_data <= n_data;
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

    // remainder never exceeds twice the partial root
    logic rem_ok;
    assign rem_ok = r_data.rem <= {2'b00, r_data.root, 1'b0};
    `ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n, r_vld, rem_ok)

endmodule

`default_nettype wire

// File: rtl/edu_back.sv
// back pipeline: branch select and saturation, then band clamp and sign (2 stages)
// depends on edu_pkg, edu_res_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module edu_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire edu_pkg::t_root            i_data,
    input  wire logic [edu_pkg::REG_W-1:0] i_narrow_band,
    edu_res_if.source                      o_res
);

    localparam int MW = edu_pkg::MAG_W;

    logic          r_b1_vld, r_b2_vld;
    logic [MW-1:0] r_b1_raw;
    logic          r_b1_neg;
    logic [MW-1:0] r_b2_raw, r_b2_sd;
    logic          r_b2_clamp;
    logic          b1_rdy, b2_rdy;

    assign b2_rdy  = !r_b2_vld || o_res.ready;
    assign b1_rdy  = !r_b1_vld || b2_rdy;
    assign o_ready = b1_rdy;

    // stage 1: upwind or quadratic result, saturated to 32 bits
    logic [MW+1:0] quad_sum;
    logic [MW:0]   u_val;
    logic [MW-1:0] n_b1_raw;
    always_comb begin
        quad_sum = {1'b0, i_data.side.pair_sum} + {2'b0, i_data.root};
        u_val    = i_data.side.upwind ? i_data.side.near_sum : quad_sum[MW+1:1];
        n_b1_raw = u_val[MW] ? '1 : u_val[MW-1:0];
    end

    // stage 2: clamp to the band and apply the cell sign
    logic          n_b2_clamp;
    logic [MW-1:0] kept, n_b2_sd;
    always_comb begin
        n_b2_clamp = r_b1_raw > {1'b0, i_narrow_band};
        kept       = n_b2_clamp ? {1'b0, i_narrow_band} : r_b1_raw;
        n_b2_sd    = r_b1_neg ? (MW'(0) - kept) : kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
        end else begin
            if (b1_rdy) r_b1_vld <= i_valid;
            if (b2_rdy) r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_rdy) begin
            r_b1_raw <= n_b1_raw;
            r_b1_neg <= i_data.side.neg;
        end
        if (b2_rdy) begin
            r_b2_raw   <= r_b1_raw;
            r_b2_sd    <= n_b2_sd;
            r_b2_clamp <= n_b2_clamp;
        end
    end

    assign o_res.valid           = r_b2_vld;
    assign o_res.raw_distance    = r_b2_raw;
    assign o_res.signed_distance = $signed(r_b2_sd);
    assign o_res.band_clamped    = r_b2_clamp;

    // an unclamped result carries the raw magnitude with either sign
    logic sign_ok;
    assign sign_ok = (r_b2_sd == r_b2_raw) || (r_b2_sd == (MW'(0) - r_b2_raw));
    `ASSERT_IMPLY(a_unclamped_mag, i_clk, i_rst_n, r_b2_vld && !r_b2_clamp, sign_ok)

endmodule

`default_nettype wire

// File: rtl/eikonal_distance_update_2d_core.sv
// Eikonal upwind distance update for one 2-D grid cell per request.
// Pipeline: 4 front stages, 32 square-root stages at one root bit each and
// 2 back stages between request acceptance and result valid.
// Throughput: one request per cycle; every stage holds under output stall.
// Reset (synchronous, active low) empties the pipeline and restores the
// grid spacing to 1.0 and the narrow band to 5.0.
`default_nettype none
`include "assert_macros.svh"

module eikonal_distance_update_2d_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire edu_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [edu_pkg::REG_W-1:0] i_cfg_data,
    edu_req_if.sink                        i_req,
    edu_res_if.source                      o_res
);

    localparam int NS = edu_pkg::ROOT_STAGES;

    edu_pkg::t_cfg  cfg;
    logic [NS:0]    w_vld, w_rdy;
    edu_pkg::t_root w_data [NS+1];

    // configuration registers
    edu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // minima, upwind test and discriminant
    edu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_grid_spacing (cfg.grid_spacing),
        .o_valid        (w_vld[0]),
        .i_ready        (w_rdy[0]),
        .o_data         (w_data[0])
    );

    // square root, one result bit per stage
    for (genvar g = 0; g < NS; g++) begin : g_root
        edu_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_data[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // result select, saturation, clamp and sign
    edu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_vld[NS]),
        .o_ready       (w_rdy[NS]),
        .i_data        (w_data[NS]),
        .i_narrow_band (cfg.narrow_band),
        .o_res         (o_res)
    );

    // requests are refused only when the whole pipeline is full and stalled
    logic out_stalled;
    assign out_stalled = o_res.valid && !o_res.ready && w_vld[0] && w_vld[NS];
    `ASSERT_IMPLY(a_ready_only_on_stall, i_clk, i_rst_n, !i_req.ready, out_stalled)

endmodule

`default_nettype wire

// File: verif/eikonal_distance_update_2d_core_test.sv
// self-checking bench for eikonal_distance_update_2d_core: cell update requests in,
// distances out, each result checked against an in-bench upwind solver
// depends on rtl/edu_pkg.sv, rtl/edu_req_if.sv, rtl/edu_res_if.sv and the core

module eikonal_distance_update_2d_core_test;

    localparam logic [31:0] UNIT     = 32'h0001_0000;
    localparam logic [31:0] FAR_MAG  = 32'hFFFF_FFFF;
    localparam int          DRAIN_GAP = 40;

    typedef struct {
        logic [31:0] left_mag;
        logic [31:0] right_mag;
        logic [31:0] below_mag;
        logic [31:0] above_mag;
        logic        has_left;
        logic        has_right;
        logic        has_below;
        logic        has_above;
        logic        center_negative;
    } t_cell;

    typedef struct {
        logic        [31:0] raw_distance;
        logic signed [31:0] signed_distance;
        logic               band_clamped;
    } t_dist;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    edu_pkg::t_cfg_idx            cfg_idx = edu_pkg::CFG_GRID_SPACING;
    logic [edu_pkg::REG_W-1:0]    cfg_data = '0;

    edu_req_if req_ch ();
    edu_res_if res_ch ();

    eikonal_distance_update_2d_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // bench copy of the two registers
    logic [edu_pkg::REG_W-1:0] spacing_reg = edu_pkg::GRID_SPACING_RST;
    logic [edu_pkg::REG_W-1:0] band_reg    = edu_pkg::NARROW_BAND_RST;

    t_cell cells_pending[$];
    t_dist dist_expected[$];
    t_cell cell_on_bus;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_go = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    int err_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int clamps_seen = 0;
    int settings_run = 1;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // floor square root, one root bit per pass from the top
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (32'd1 << i);
            if ({32'b0, trial} * {32'b0, trial} <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // godunov upwind solve for one cell under the current spacing and band
    function automatic t_dist solve_cell(input t_cell c);
        logic [31:0] lm, rm, bm, am, ax, ay, raw, kept;
        logic [63:0] dx, lo, hi, diff, disc, u;
        t_dist d;
        lm = c.has_left  ? c.left_mag  : FAR_MAG;
        rm = c.has_right ? c.right_mag : FAR_MAG;
        bm = c.has_below ? c.below_mag : FAR_MAG;
        am = c.has_above ? c.above_mag : FAR_MAG;
        ax = (lm < rm) ? lm : rm;
        ay = (bm < am) ? bm : am;
        lo = {32'b0, (ax < ay) ? ax : ay};
        hi = {32'b0, (ax < ay) ? ay : ax};
        dx = {33'b0, spacing_reg};
        diff = hi - lo;
        if (diff >= dx) begin
            u = lo + dx;
        end else begin
            disc = 64'd2 * dx * dx - diff * diff;
            u = ({32'b0, ax} + {32'b0, ay} + {32'b0, floor_root(disc)}) >> 1;
        end
        raw = (u > 64'h0000_0000_FFFF_FFFF) ? FAR_MAG : u[31:0];
        d.raw_distance = raw;
        d.band_clamped = raw > {1'b0, band_reg};
        kept = d.band_clamped ? {1'b0, band_reg} : raw;
        d.signed_distance = c.center_negative ? -kept : kept;
        return d;
    endfunction

    function automatic t_cell mk_cell(input logic [31:0] l, input logic [31:0] r,
                                      input logic [31:0] b, input logic [31:0] a,
                                      input logic [3:0] present, input logic neg);
        t_cell c;
        c.left_mag  = l;
        c.right_mag = r;
        c.below_mag = b;
        c.above_mag = a;
        {c.has_left, c.has_right, c.has_below, c.has_above} = present;
        c.center_negative = neg;
        return c;
    endfunction

    // put axis minimum m on one side, the other side no smaller, far or missing
    function automatic void place_min(input logic [31:0] m, output logic [31:0] p,
                                      output logic [31:0] q, output logic hp,
                                      output logic hq);
        logic [63:0] big;
        logic [31:0] other;
        logic        has_other;
        big = {32'b0, m} + {32'b0, $urandom >> $urandom_range(31)};
        other = (big > 64'h0000_0000_FFFF_FFFF) ? FAR_MAG : big[31:0];
        has_other = 1'b1;
        case ($urandom_range(3))
            0: begin
                other = $urandom;
                has_other = 1'b0;
            end
            1: other = FAR_MAG;
            default: ;
        endcase
        if ($urandom_range(1) == 0) begin
            p = m;
            hp = 1'b1;
            q = other;
            hq = has_other;
        end else begin
            p = other;
            hp = has_other;
            q = m;
            hq = 1'b1;
        end
    endfunction

    function automatic t_cell random_cell();
        t_cell c;
        int unsigned pick;
        logic [63:0] dx, base, off, v;
        c.left_mag  = $urandom;
        c.right_mag = $urandom;
        c.below_mag = $urandom;
        c.above_mag = $urandom;
        {c.has_left, c.has_right, c.has_below, c.has_above} = 4'($urandom_range(15));
        c.center_negative = 1'($urandom_range(1));
        dx = {33'b0, spacing_reg};
        pick = $urandom_range(99);
        if (pick < 50) begin
            // axis minima within about one spacing: mostly the quadratic branch
            base = {32'b0, $urandom >> $urandom_range(31)};
            off = {$urandom, $urandom} % (64'd2 * dx + 64'd1);
            v = base + off;
            v = (v < dx) ? 64'd0 : v - dx;
            if (v > 64'h0000_0000_FFFF_FFFF) v = {32'b0, FAR_MAG};
            place_min(base[31:0], c.left_mag, c.right_mag, c.has_left, c.has_right);
            place_min(v[31:0], c.below_mag, c.above_mag, c.has_below, c.has_above);
        end else if (pick < 65) begin
            // one axis entirely missing
            if ($urandom_range(1) == 0) begin
                {c.has_left, c.has_right} = 2'b00;
            end else begin
                {c.has_below, c.has_above} = 2'b00;
            end
        end else if (pick < 80) begin
            // small distances, all neighbors present
            c.left_mag  = $urandom_range(8 * UNIT);
            c.right_mag = $urandom_range(8 * UNIT);
            c.below_mag = $urandom_range(8 * UNIT);
            c.above_mag = $urandom_range(8 * UNIT);
            {c.has_left, c.has_right, c.has_below, c.has_above} = 4'b1111;
        end
        return c;
    endfunction

    // append one cell to the pending requests
    task automatic add_cell(input t_cell c);
        cells_pending = {cells_pending, c};
    endtask

    task automatic queue_random(input int n);
        repeat (n) add_cell(random_cell());
    endtask

    // sender holds off until every request has come back
    task automatic wait_drain();
        while (cells_pending.size() != 0 || req_ch.valid || dist_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_reg(input edu_pkg::t_cfg_idx idx,
                             input logic [edu_pkg::REG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == edu_pkg::CFG_GRID_SPACING) begin
            spacing_reg = val;
        end else begin
            band_reg = val;
        end
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [edu_pkg::REG_W-1:0] spacing,
                            input logic [edu_pkg::REG_W-1:0] band);
        write_reg(edu_pkg::CFG_GRID_SPACING, spacing);
        write_reg(edu_pkg::CFG_NARROW_BAND, band);
        settings_run++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                dist_expected = {dist_expected, solve_cell(cell_on_bus)};
                requests_sent++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (cells_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cell_on_bus = cells_pending.pop_front();
                    req_ch.valid           <= 1'b1;
                    req_ch.left_mag        <= cell_on_bus.left_mag;
                    req_ch.right_mag       <= cell_on_bus.right_mag;
                    req_ch.below_mag       <= cell_on_bus.below_mag;
                    req_ch.above_mag       <= cell_on_bus.above_mag;
                    req_ch.has_left        <= cell_on_bus.has_left;
                    req_ch.has_right       <= cell_on_bus.has_right;
                    req_ch.has_below       <= cell_on_bus.has_below;
                    req_ch.has_above       <= cell_on_bus.has_above;
                    req_ch.center_negative <= cell_on_bus.center_negative;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, armed once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go && !hold_used) begin
            hold_left <= 300;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin : result_check
        t_dist want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (dist_expected.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = dist_expected.pop_front();
                    results_seen++;
                    if (want.band_clamped) clamps_seen++;
                    if (res_ch.raw_distance !== want.raw_distance) begin
                        report_mismatch($sformatf("raw_distance got %h expected %h",
                                        res_ch.raw_distance, want.raw_distance));
                    end
                    if (res_ch.signed_distance !== want.signed_distance) begin
                        report_mismatch($sformatf("signed_distance got %h expected %h",
                                        res_ch.signed_distance, want.signed_distance));
                    end
                    if (res_ch.band_clamped !== want.band_clamped) begin
                        report_mismatch($sformatf("band_clamped got %b expected %b",
                                        res_ch.band_clamped, want.band_clamped));
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus and sequencing
    initial begin
        req_ch.valid           = 1'b0;
        req_ch.left_mag        = '0;
        req_ch.right_mag       = '0;
        req_ch.below_mag       = '0;
        req_ch.above_mag       = '0;
        req_ch.has_left        = 1'b0;
        req_ch.has_right       = 1'b0;
        req_ch.has_below       = 1'b0;
        req_ch.has_above       = 1'b0;
        req_ch.center_negative = 1'b0;
        res_ch.ready           = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: spacing 1.0, band 5.0
        send_idle_pct = 30;
        recv_idle_pct = 55;
        add_cell(mk_cell(0, 0, 0, 0, 4'b0000, 1'b0));
        add_cell(mk_cell(FAR_MAG, FAR_MAG, FAR_MAG, FAR_MAG, 4'b1111, 1'b1));
        add_cell(mk_cell(0, 0, 0, 0, 4'b1111, 1'b0));
        add_cell(mk_cell(3 * UNIT, 0, 0, 0, 4'b1000, 1'b0));
        add_cell(mk_cell(2 * UNIT, FAR_MAG, 2 * UNIT, FAR_MAG, 4'b1111, 1'b1));
        add_cell(mk_cell(UNIT, 5 * UNIT, 2 * UNIT, 7 * UNIT, 4'b1111, 1'b0));
        add_cell(mk_cell(UNIT, 5 * UNIT, 2 * UNIT - 1, 7 * UNIT, 4'b1111, 1'b0));
        add_cell(mk_cell(10 * UNIT, 10 * UNIT, 10 * UNIT, 10 * UNIT, 4'b1111, 1'b1));
        add_cell(mk_cell(4 * UNIT, 0, 0, 0, 4'b1000, 1'b1));
        add_cell(mk_cell(4 * UNIT + 1, 0, 0, 0, 4'b1000, 1'b0));
        add_cell(mk_cell(FAR_MAG, 3 * UNIT, 6 * UNIT, 2 * UNIT, 4'b1111, 1'b0));
        add_cell(mk_cell(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                         32'hFFFF_FFFE, 4'b1111, 1'b0));
        add_cell(mk_cell(FAR_MAG, 0, 0, 0, 4'b1010, 1'b1));
        add_cell(mk_cell(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                         32'hAAAA_AAAA, 4'b0101, 1'b1));
        wait_drain();
        queue_random(150);
        wait_drain();

        // widest spacing and band
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_cell(mk_cell(0, 0, 0, 0, 4'b1111, 1'b0));
        add_cell(mk_cell(0, 0, 0, 0, 4'b0000, 1'b1));
        add_cell(mk_cell(0, 0, 0, 0, 4'b1000, 1'b0));
        add_cell(mk_cell(UNIT, 0, 32'h8000_0000, 0, 4'b1010, 1'b1));
        queue_random(120);
        wait_drain();

        // finest spacing, zero band
        send_idle_pct = 55;
        recv_idle_pct = 30;
        set_regs(31'd1, 31'd0);
        add_cell(mk_cell(0, 0, 0, 0, 4'b1111, 1'b1));
        add_cell(mk_cell(5, 5, 6, 6, 4'b1111, 1'b0));
        add_cell(mk_cell(FAR_MAG, FAR_MAG, FAR_MAG, FAR_MAG, 4'b1111, 1'b1));
        queue_random(150);
        wait_drain();

        // zero spacing: result is the smaller axis minimum
        set_regs(31'd0, edu_pkg::NARROW_BAND_RST);
        add_cell(mk_cell(0, 0, 0, 0, 4'b1111, 1'b1));
        add_cell(mk_cell(7 * UNIT, 7 * UNIT, 7 * UNIT, 7 * UNIT, 4'b1111, 1'b0));
        add_cell(mk_cell(3 * UNIT, 0, 2 * UNIT, 0, 4'b1010, 1'b1));
        queue_random(100);
        wait_drain();

        // moderate random settings, no idling, long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(31'($urandom_range(1, 8 * UNIT)), 31'($urandom_range(64 * UNIT)));
        queue_random(100);
        hold_go = 1'b1;
        wait_drain();

        // large random spacing and band
        set_regs(31'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)), 31'($urandom >> 1));
        queue_random(80);
        wait_drain();

        $display("%0d requests sent, %0d results checked, %0d clamped to the band",
                 requests_sent, results_seen, clamps_seen);
        $display("%0d register settings incl. extremes, zero spacing and zero band",
                 settings_run);
        if (err_count == 0 && dist_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", dist_expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
